FILE: sv/u16u8_pkg.sv
// ---------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 encode helpers for the UTF-16 to UTF-8
// transcoder with cursor mapping.
// ---------------------------------------------------------------------------
package u16u8_pkg;

  // String limits
  localparam int MAX_UNITS = 65536;
  localparam int UNIT_W    = $clog2(MAX_UNITS + 1);
  localparam int CURSOR_W  = 17;
  localparam int CMP_W     = (UNIT_W > CURSOR_W) ? UNIT_W : CURSOR_W;
  localparam int BYTES_W   = 18;
  localparam logic [BYTES_W-1:0] BYTE_SAT = '1;

  // Code point and surrogate constants
  localparam int CP_W = 21;
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // Register map
  localparam int PADDR_W = 3;
  localparam logic REG_CURSOR_UNITS = 1'b0;

  // Decoupling queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One work item between front and back: one or two code points to emit
  typedef struct packed {
    logic [CP_W-1:0]    cp0;
    logic [CP_W-1:0]    cp1;
    logic               has1;
    logic               last;
    logic [BYTES_W-1:0] cursor;
  } entry_t;

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] len;
    if (cp < 21'h80)         len = 3'd1;
    else if (cp < 21'h800)   len = 3'd2;
    else if (cp < 21'h10000) len = 3'd3;
    else                     len = 3'd4;
    return len;
  endfunction

  // Byte idx of the UTF-8 encoding of a code point
  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0]      idx);
    logic [2:0] len;
    logic [7:0] b;
    len = utf8_len(cp);
    b = cp[7:0];
    case (len)
      3'd2: begin
        b = (idx == 2'd0) ? (LEAD2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0]});
      end
      3'd3: begin
        case (idx)
          2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
          2'd1:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
          2'd1:    b = CONT | {2'b00, cp[17:12]};
          2'd2:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

  // Saturating byte-count add
  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [2:0]         n);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {{(BYTES_W-2){1'b0}}, n};
    return s[BYTES_W] ? BYTE_SAT : s[BYTES_W-1:0];
  endfunction

endpackage

FILE: sv/utf16_to_utf8_with_cursor_unit.sv
// ---------------------------------------------------------------------------
// utf16_to_utf8_with_cursor_unit
// UTF-16 to UTF-8 transcoder that also maps a cursor unit index to a byte
// offset, reported with the final byte of each string.
// ---------------------------------------------------------------------------
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+------------------
//  unit     | unit_valid, unit_stall, code_unit, last_unit | UTF-16 in
//  byte     | byte_valid, byte_stall, out_byte, last_byte, | UTF-8 out
//           | cursor_byte                               |
//  config   | psel, penable, pwrite, paddr, pwdata,     | cursor_units reg
//           | prdata, pready                            |
//
//  One code unit can be accepted every cycle while the queue is not full;
//  the byte side gives one beat per cycle unless byte_stall holds it, so a
//  unit is paced by the bytes it emits (a held high surrogate emits none,
//  a flush plus a 3-byte unit six). The single-port byte expander sets that
//  rate; a 4-entry queue absorbs it. A unit's first byte passes through the
//  queue and then the output register. Synchronous reset clears string state,
//  the queue and cursor_units. byte_stall holds the output beat; unit_stall
//  rises only when the queue is full.
// ---------------------------------------------------------------------------
module utf16_to_utf8_with_cursor_unit (
  input  logic                              clk,
  input  logic                              rst,
  // code unit channel
  input  logic                              unit_valid,
  output logic                              unit_stall,
  input  logic [15:0]                       code_unit,
  input  logic                              last_unit,
  // byte channel
  output logic                              byte_valid,
  input  logic                              byte_stall,
  output logic [7:0]                        out_byte,
  output logic                              last_byte,
  output logic [u16u8_pkg::BYTES_W-1:0]     cursor_byte,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [u16u8_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [u16u8_pkg::CURSOR_W-1:0] cursor_units;
  logic                           q_full, q_push, q_pop, q_head_valid;
  u16u8_pkg::entry_t              q_in, q_head;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == u16u8_pkg::REG_CURSOR_UNITS)
                  ? {{(32-u16u8_pkg::CURSOR_W){1'b0}}, cursor_units} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_units <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == u16u8_pkg::REG_CURSOR_UNITS)) begin
      cursor_units <= pwdata[u16u8_pkg::CURSOR_W-1:0];
    end
  end

  u16u8_front u_front (
    .clk          (clk),
    .rst          (rst),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .code_unit    (code_unit),
    .last_unit    (last_unit),
    .cursor_units (cursor_units),
    .q_full       (q_full),
    .push         (q_push),
    .push_entry   (q_in)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .out_byte    (out_byte),
    .last_byte   (last_byte),
    .cursor_byte (cursor_byte)
  );

endmodule

FILE: sv/u16u8_front.sv
// ---------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, tracks unit and byte counts and the
// cursor offset, and pushes the code points to emit into the queue.
// ---------------------------------------------------------------------------
module u16u8_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                unit_valid,
  output logic                                unit_stall,
  input  logic [15:0]                         code_unit,
  input  logic                                last_unit,
  input  logic [u16u8_pkg::CURSOR_W-1:0]      cursor_units,
  input  logic                                q_full,
  output logic                                push,
  output u16u8_pkg::entry_t                   push_entry
);

  // String state
  logic [15:0]                       held_high;
  logic                              held_valid;
  logic [u16u8_pkg::UNIT_W-1:0]      unit_index;
  logic [u16u8_pkg::BYTES_W-1:0]     bytes_emitted;
  logic [u16u8_pkg::BYTES_W-1:0]     cursor_offset;

  logic [15:0]                       held_high_next;
  logic                              held_valid_next;
  logic [u16u8_pkg::UNIT_W-1:0]      unit_index_next;
  logic [u16u8_pkg::BYTES_W-1:0]     bytes_emitted_next;
  logic [u16u8_pkg::BYTES_W-1:0]     cursor_offset_next;

  logic                              accept;
  logic                              is_high, is_low, starts;
  logic                              has_a, has_b;
  logic [u16u8_pkg::CP_W-1:0]        cp_a, cp_b;
  logic [u16u8_pkg::BYTES_W-1:0]     bytes_a, bytes_b, co_a, co_b;
  logic                              unit_sat;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;

  // Classify and work out the code points of this unit
  always_comb begin
    is_high  = (code_unit >= u16u8_pkg::HIGH_FIRST) && (code_unit <= u16u8_pkg::HIGH_LAST);
    is_low   = (code_unit >= u16u8_pkg::LOW_FIRST) && (code_unit <= u16u8_pkg::LOW_LAST);
    unit_sat = (u16u8_pkg::CMP_W'(unit_index) >= u16u8_pkg::CMP_W'(u16u8_pkg::MAX_UNITS));

    // flush of a held high surrogate, joined with a low one when it follows
    has_a  = held_valid;
    starts = !(held_valid && is_low);
    if (held_valid && is_low) begin
      cp_a = u16u8_pkg::SUPP_BASE + {1'b0, held_high[9:0], code_unit[9:0]};
    end else begin
      cp_a = {5'b00000, held_high};
    end
    bytes_a = has_a ? u16u8_pkg::sat_add(bytes_emitted, u16u8_pkg::utf8_len(cp_a))
                    : bytes_emitted;

    // cursor on the start of this unit's code point
    co_a = cursor_offset;
    if (starts && !unit_sat &&
        (u16u8_pkg::CMP_W'(unit_index) == u16u8_pkg::CMP_W'(cursor_units))) begin
      co_a = bytes_a;
    end

    // the unit itself: held if a high surrogate with more to come
    cp_b  = {5'b00000, code_unit};
    has_b = starts && !(is_high && !last_unit);
    bytes_b = has_b ? u16u8_pkg::sat_add(bytes_a, u16u8_pkg::utf8_len(cp_b)) : bytes_a;

    unit_index_next = unit_sat ? unit_index : unit_index + 1'b1;

    // cursor at or past the end
    co_b = co_a;
    if (last_unit && (u16u8_pkg::CMP_W'(cursor_units) >= u16u8_pkg::CMP_W'(unit_index_next))) begin
      co_b = bytes_b;
    end

    held_high_next     = (starts && is_high && !last_unit) ? code_unit : 16'h0000;
    held_valid_next    = starts && is_high && !last_unit;
    bytes_emitted_next = bytes_b;
    cursor_offset_next = co_b;
    if (last_unit) begin
      held_high_next     = 16'h0000;
      held_valid_next    = 1'b0;
      unit_index_next    = '0;
      bytes_emitted_next = '0;
      cursor_offset_next = '0;
    end
  end

  // Queue entry: slot 0 always holds the first code point
  always_comb begin
    push              = accept && (has_a || has_b);
    push_entry.cp0    = has_a ? cp_a : cp_b;
    push_entry.cp1    = cp_b;
    push_entry.has1   = has_a && has_b;
    push_entry.last   = last_unit;
    push_entry.cursor = co_b;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_high     <= '0;
      held_valid    <= 1'b0;
      unit_index    <= '0;
      bytes_emitted <= '0;
      cursor_offset <= '0;
    end else if (accept) begin
      held_high     <= held_high_next;
      held_valid    <= held_valid_next;
      unit_index    <= unit_index_next;
      bytes_emitted <= bytes_emitted_next;
      cursor_offset <= cursor_offset_next;
    end
  end

endmodule

FILE: sv/u16u8_queue.sv
// ---------------------------------------------------------------------------
// u16u8_queue
// Short FIFO of work items between the front and the back.
// ---------------------------------------------------------------------------
module u16u8_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u16u8_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u16u8_pkg::entry_t head
);

  u16u8_pkg::entry_t                mem [u16u8_pkg::QDEPTH];
  logic [u16u8_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [u16u8_pkg::QCNT_W-1:0]     count;

  assign full       = (count == u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/u16u8_back.sv
// ---------------------------------------------------------------------------
// u16u8_back
// Expands queued code points into UTF-8 bytes, one beat per cycle unless
// byte_stall holds the output, through an output register.
// ---------------------------------------------------------------------------
module u16u8_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  u16u8_pkg::entry_t               head,
  output logic                            pop,
  output logic                            byte_valid,
  input  logic                            byte_stall,
  output logic [7:0]                      out_byte,
  output logic                            last_byte,
  output logic [u16u8_pkg::BYTES_W-1:0]   cursor_byte
);

  logic                          seg;
  logic [1:0]                    idx;
  logic [u16u8_pkg::CP_W-1:0]    cp;
  logic [2:0]                    len;
  logic                          cp_done, item_done, load;

  // Walk position within the head item
  always_comb begin
    cp        = seg ? head.cp1 : head.cp0;
    len       = u16u8_pkg::utf8_len(cp);
    cp_done   = ({1'b0, idx} == len - 3'd1);
    item_done = cp_done && (seg || !head.has1);
    load      = head_valid && (!byte_valid || !byte_stall);
    pop       = load && item_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      if (cp_done) begin
        seg <= !item_done;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || !byte_stall) begin
      byte_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= u16u8_pkg::utf8_byte(cp, idx);
      last_byte   <= item_done && head.last;
      cursor_byte <= (item_done && head.last) ? head.cursor : '0;
    end
  end

endmodule

FILE: sv/u16u8_checker.sv
// ---------------------------------------------------------------------------
// u16u8_checker
// Port-level checks for the transcoder, bound to the top level.
// ---------------------------------------------------------------------------
module u16u8_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              byte_valid,
  input logic                              byte_stall,
  input logic [7:0]                        out_byte,
  input logic                              last_byte,
  input logic [u16u8_pkg::BYTES_W-1:0]     cursor_byte,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [u16u8_pkg::PADDR_W-1:0]     paddr,
  input logic [31:0]                       pwdata,
  input logic [31:0]                       prdata,
  input logic                              pready
);

  // Output is idle right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !byte_valid)
    else $error("byte_valid high after reset");

  // Cursor offset only rides on the final byte
  a_cursor_final: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !last_byte |-> cursor_byte == '0)
    else $error("cursor_byte nonzero on a non-final byte");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(out_byte) &&
                                 $stable(last_byte) && $stable(cursor_byte))
    else $error("stalled byte beat changed");

  // Cursor register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2]
      |=> paddr[2] || prdata[u16u8_pkg::CURSOR_W-1:0] ==
                      $past(pwdata[u16u8_pkg::CURSOR_W-1:0]))
    else $error("cursor_units readback mismatch");

endmodule

bind utf16_to_utf8_with_cursor_unit u16u8_checker u_checker (.*);

FILE: sim/utf16_to_utf8_with_cursor_unit_tb.sv
// ---------------------------------------------------------------------------
// utf16_to_utf8_with_cursor_unit_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A directed table
// covers the encoding extremes, surrogate pairs, unpaired surrogates and the
// cursor cases. Random strings follow in three idling phases. Each byte beat
// is checked against typed bytes or a transcoding predictor in this file.
// ---------------------------------------------------------------------------
module utf16_to_utf8_with_cursor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [u16u8_pkg::PADDR_W-1:0] CURSOR_ADDR =
    u16u8_pkg::PADDR_W'(4 * u16u8_pkg::REG_CURSOR_UNITS);
  localparam int                 CURSOR_END  = 65536;
  localparam int                 PHASE_UNITS = 105;

  // One expected beat on the byte channel
  typedef struct packed {
    logic [7:0]                    data;
    logic                          fin;
    logic [u16u8_pkg::BYTES_W-1:0] cursor;
  } utf8_beat_t;

  // Directed table rows
  typedef enum logic [1:0] {ROW_CURSOR, ROW_UNIT, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [16:0]                   value;   // cursor for ROW_CURSOR, code unit otherwise
    logic                          fin;
    logic [2:0]                    n;       // typed byte count, ROW_KNOWN only
    logic [31:0]                   bytes;   // typed bytes, first byte in the top lane
    logic [u16u8_pkg::BYTES_W-1:0] cursor;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          unit_valid;
  logic                          unit_stall;
  logic [15:0]                   code_unit;
  logic                          last_unit;
  logic                          byte_valid;
  logic                          byte_stall;
  logic [7:0]                    out_byte;
  logic                          last_byte;
  logic [u16u8_pkg::BYTES_W-1:0] cursor_byte;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [u16u8_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // Typed expectation riding along with the current unit
  logic                          known_now;
  logic [2:0]                    known_n;
  logic [31:0]                   known_bytes;
  logic [u16u8_pkg::BYTES_W-1:0] known_cursor;

  // Predictor state
  logic [16:0]                   cfg_cursor;
  logic [15:0]                   held_unit;
  logic                          held_ok;
  logic [16:0]                   units_seen;
  logic [u16u8_pkg::BYTES_W-1:0] bytes_out;
  logic [u16u8_pkg::BYTES_W-1:0] cursor_mark;

  utf8_beat_t         step_q[$];
  utf8_beat_t         pending_utf8[$];
  dir_row_t           dir_tbl[$];

  int                 err_cnt;
  int                 units_sent;
  int                 send_gap_pct;
  int                 recv_stall_pct;

  utf16_to_utf8_with_cursor_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .code_unit   (code_unit),
    .last_unit   (last_unit),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .out_byte    (out_byte),
    .last_byte   (last_byte),
    .cursor_byte (cursor_byte),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predictor: append one byte, count saturates
  task automatic put_byte(input logic [7:0] b);
    utf8_beat_t beat;
    beat.data   = b;
    beat.fin    = 1'b0;
    beat.cursor = '0;
    step_q = {step_q, beat};
    if (bytes_out != '1) bytes_out = bytes_out + 1'b1;
  endtask

  // Predictor: UTF-8 encode one code point
  task automatic put_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endtask

  // Predictor: bytes caused by one accepted code unit, left in step_q
  task automatic transcode_unit(input logic [15:0] u, input logic fin);
    logic        is_hi;
    logic        is_lo;
    logic        starts;
    logic [20:0] cp;
    is_hi  = (u >= u16u8_pkg::HIGH_FIRST) && (u <= u16u8_pkg::HIGH_LAST);
    is_lo  = (u >= u16u8_pkg::LOW_FIRST) && (u <= u16u8_pkg::LOW_LAST);
    starts = 1'b1;
    step_q.delete();
    // resolve a held high surrogate first
    if (held_ok) begin
      if (is_lo) begin
        cp = 21'h10000 + ({11'd0, held_unit[9:0]} << 10) + {11'd0, u[9:0]};
        put_code_point(cp);
        starts = 1'b0;
      end else begin
        put_code_point({5'd0, held_unit});
      end
      held_ok   = 1'b0;
      held_unit = '0;
    end
    if (starts) begin
      if (units_seen < 17'(CURSOR_END) && units_seen == cfg_cursor) cursor_mark = bytes_out;
      if (is_hi && !fin) begin
        held_unit = u;
        held_ok   = 1'b1;
      end else begin
        put_code_point({5'd0, u});
      end
    end
    if (units_seen < 17'(CURSOR_END)) units_seen = units_seen + 1'b1;
    // end of string: cursor past the end, tag the final byte, clear
    if (fin) begin
      if (cfg_cursor >= units_seen) cursor_mark = bytes_out;
      if (step_q.size() > 0) begin
        step_q[step_q.size()-1].fin    = 1'b1;
        step_q[step_q.size()-1].cursor = cursor_mark;
      end
      held_unit   = '0;
      held_ok     = 1'b0;
      units_seen  = '0;
      bytes_out   = '0;
      cursor_mark = '0;
    end
  endtask

  // Unit acceptance feeds the predictor; byte acceptance is checked
  always @(posedge clk) begin : scoreboard
    utf8_beat_t beat;
    if (!rst) begin
      if (unit_valid && !unit_stall) begin
        transcode_unit(code_unit, last_unit);
        if (known_now) begin
          for (int k = 0; k < known_n; k++) begin
            beat.data   = known_bytes[31-8*k -: 8];
            beat.fin    = last_unit && (k == known_n - 1);
            beat.cursor = beat.fin ? known_cursor : '0;
            pending_utf8 = {pending_utf8, beat};
          end
        end else begin
          foreach (step_q[k]) pending_utf8 = {pending_utf8, step_q[k]};
        end
      end
      if (byte_valid && !byte_stall) begin
        if (pending_utf8.size() == 0) begin
          $error("out_byte: no beat expected, got %h", out_byte);
          err_cnt++;
        end else begin
          beat = pending_utf8.pop_front();
          if (out_byte !== beat.data) begin
            $error("out_byte: expected %h, got %h", beat.data, out_byte);
            err_cnt++;
          end
          if (last_byte !== beat.fin) begin
            $error("last_byte: expected %b, got %b", beat.fin, last_byte);
            err_cnt++;
          end
          if (cursor_byte !== beat.cursor) begin
            $error("cursor_byte: expected %0d, got %0d", beat.cursor, cursor_byte);
            err_cnt++;
          end
        end
      end
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    byte_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Send one unit: random gap, then hold until accepted
  task automatic drive_unit(input logic [15:0] u, input logic fin, input logic known,
                            input logic [2:0] n, input logic [31:0] bytes,
                            input logic [u16u8_pkg::BYTES_W-1:0] cur);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      unit_valid <= 1'b0;
      @(negedge clk);
    end
    unit_valid   <= 1'b1;
    code_unit    <= u;
    last_unit    <= fin;
    known_now    <= known;
    known_n      <= n;
    known_bytes  <= bytes;
    known_cursor <= cur;
    do @(posedge clk); while (unit_stall);
    units_sent++;
  endtask

  // Drain, then write the cursor register and read it back
  task automatic set_cursor(input logic [16:0] value);
    @(negedge clk);
    unit_valid <= 1'b0;
    while (pending_utf8.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CURSOR_ADDR;
    pwdata  <= {15'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_cursor = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {15'd0, value}) begin
      $error("cursor_units: expected %0d, got %0d", value, prdata);
      err_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random unit that encodes to three bytes
  function automatic logic [15:0] three_byte_unit();
    logic [15:0] u;
    u = 16'($urandom_range(16'hFFFF, 16'h0800));
    if (u >= u16u8_pkg::HIGH_FIRST && u <= u16u8_pkg::LOW_LAST) u = u ^ 16'h2000;
    return u;
  endfunction

  function automatic logic [16:0] pick_cursor();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return 17'(CURSOR_END);
    if (r == 2) return 17'($urandom_range(CURSOR_END));
    return 17'($urandom_range(14));
  endfunction

  // Mostly well-formed text, with unpaired surrogates and raw noise
  task automatic send_random_string(input int len);
    logic [15:0] units[$];
    int          pick;
    while (units.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        units = {units, 16'($urandom_range(16'h7F))};
      end else if (pick < 42) begin
        units = {units, 16'($urandom_range(16'h7FF, 16'h80))};
      end else if (pick < 54) begin
        units = {units, three_byte_unit()};
      end else if (pick < 74) begin
        units = {units, 16'($urandom_range(u16u8_pkg::HIGH_LAST, u16u8_pkg::HIGH_FIRST))};
        units = {units, 16'($urandom_range(u16u8_pkg::LOW_LAST, u16u8_pkg::LOW_FIRST))};
      end else if (pick < 80) begin
        units = {units, 16'($urandom_range(u16u8_pkg::HIGH_LAST, u16u8_pkg::HIGH_FIRST))};
      end else if (pick < 85) begin
        units = {units, 16'($urandom_range(u16u8_pkg::LOW_LAST, u16u8_pkg::LOW_FIRST))};
      end else begin
        units = {units, 16'($urandom_range(16'hFFFF))};
      end
    end
    foreach (units[k]) drive_unit(units[k], k == units.size() - 1, 1'b0, '0, '0, '0);
  endtask

  function automatic dir_row_t row(input row_kind_t kind, input logic [16:0] value,
                                   input logic fin, input logic [2:0] n,
                                   input logic [31:0] bytes,
                                   input logic [u16u8_pkg::BYTES_W-1:0] cur);
    dir_row_t r;
    r.kind   = kind;
    r.value  = value;
    r.fin    = fin;
    r.n      = n;
    r.bytes  = bytes;
    r.cursor = cur;
    return r;
  endfunction

  // Timeout
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Main sequence
  initial begin
    int phase;
    int len;
    int strings;
    rst          = 1'b1;
    unit_valid   = 1'b0;
    code_unit    = '0;
    last_unit    = 1'b0;
    byte_stall   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    known_now    = 1'b0;
    known_n      = '0;
    known_bytes  = '0;
    known_cursor = '0;
    cfg_cursor   = '0;
    held_unit    = '0;
    held_ok      = 1'b0;
    units_seen   = '0;
    bytes_out    = '0;
    cursor_mark  = '0;
    err_cnt      = 0;
    units_sent   = 0;
    send_gap_pct   = 14;
    recv_stall_pct = 84;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: encoding extremes and surrogates with the cursor at 0
    dir_tbl = {dir_tbl, row(ROW_CURSOR, 17'd0,    1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'h0000, 1'b1, 3'd1, 32'h00000000, '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'h007F, 1'b1, 3'd1, 32'h7F000000, '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'h07FF, 1'b1, 3'd2, 32'hDFBF0000, '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'hFFFF, 1'b1, 3'd3, 32'hEFBFBF00, '0)};
    // high surrogate as the final unit, lone low surrogate
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'hD800, 1'b1, 3'd3, 32'hEDA08000, '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'hDFFF, 1'b1, 3'd3, 32'hEDBFBF00, '0)};
    // lowest and highest surrogate pairs
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'hD800, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'hDC00, 1'b1, 3'd4, 32'hF0908080, '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'hDBFF, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_KNOWN,  17'hDFFF, 1'b1, 3'd4, 32'hF48FBFBF, '0)};
    // held high surrogate flushed by a plain unit
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'hDBFF, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0041, 1'b1, 3'd0, 32'h0,        '0)};
    // cursor on a pair start, then on a unit right after a flush
    dir_tbl = {dir_tbl, row(ROW_CURSOR, 17'd1,    1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0041, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'hD83D, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'hDE00, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0042, 1'b1, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'hD800, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0041, 1'b1, 3'd0, 32'h0,        '0)};
    // cursor inside a pair, then exactly at the end
    dir_tbl = {dir_tbl, row(ROW_CURSOR, 17'd2,    1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0041, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'hD83D, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'hDE00, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0042, 1'b1, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0043, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0044, 1'b1, 3'd0, 32'h0,        '0)};
    // cursor far past the end
    dir_tbl = {dir_tbl, row(ROW_CURSOR, 17'(CURSOR_END), 1'b0, 3'd0, 32'h0, '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h0041, 1'b0, 3'd0, 32'h0,        '0)};
    dir_tbl = {dir_tbl, row(ROW_UNIT,   17'h00E9, 1'b1, 3'd0, 32'h0,        '0)};

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].kind == ROW_CURSOR) begin
        set_cursor(dir_tbl[k].value);
      end else begin
        drive_unit(dir_tbl[k].value[15:0], dir_tbl[k].fin, dir_tbl[k].kind == ROW_KNOWN,
                   dir_tbl[k].n, dir_tbl[k].bytes, dir_tbl[k].cursor);
      end
    end

    // Random strings in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 14 : (phase == 1) ? 84 : 0;
      recv_stall_pct = (phase == 0) ? 84 : (phase == 1) ? 14 : 0;
      units_sent = 0;
      strings    = 0;
      while (units_sent < PHASE_UNITS) begin
        if (strings % 5 == 0) set_cursor(pick_cursor());
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
        send_random_string(len);
        strings++;
      end
    end

    // Drain and let any stray beat show up
    @(negedge clk);
    unit_valid <= 1'b0;
    while (pending_utf8.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/u16u8_pkg.sv
sv/u16u8_front.sv
sv/u16u8_queue.sv
sv/u16u8_back.sv
sv/utf16_to_utf8_with_cursor_unit.sv
sv/u16u8_checker.sv
sim/utf16_to_utf8_with_cursor_unit_tb.sv
